// File: rtl/gif_block_stream_parser_top_macros.svh
// ----------------------------------------------------------------------------
// gif block stream parser assertion macros
// shared concurrent assertion forms for the parser checker
// ----------------------------------------------------------------------------
`ifndef GIF_BLOCK_STREAM_PARSER_TOP_MACROS_SVH
`define GIF_BLOCK_STREAM_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define GBSP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/gbsp_pkg.sv
// ----------------------------------------------------------------------------
// gbsp_pkg
// types, byte codes and small lookup functions of the gif block stream parser
// ----------------------------------------------------------------------------
package gbsp_pkg;

   typedef enum logic [3:0] {
      REGION_HEADER    = 4'd0,
      REGION_GLOBAL    = 4'd1,
      REGION_GCE       = 4'd2,
      REGION_LOOP_EXT  = 4'd3,
      REGION_OTHER_EXT = 4'd4,
      REGION_DESC      = 4'd5,
      REGION_LOCAL     = 4'd6,
      REGION_IMAGE     = 4'd7,
      REGION_TRAILER   = 4'd8,
      REGION_STRAY     = 4'd9,
      REGION_AFTER_END = 4'd10,
      REGION_BAD       = 4'd11
   } region_type;

   localparam logic [7:0] EXT_INTRO     = 8'h21;
   localparam logic [7:0] LABEL_GCE     = 8'hF9;
   localparam logic [7:0] LABEL_APP     = 8'hFF;
   localparam logic [7:0] IMAGE_SEP     = 8'h2C;
   localparam logic [7:0] TRAILER_BYTE  = 8'h3B;
   localparam logic [7:0] APP_ID_SIZE   = 8'h0B;
   localparam int         TABLE_FLAG    = 7;
   localparam logic [3:0] LOOP_ID_LEN   = 4'd11;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic [3:0]  region;
      logic [15:0] frame_number;
      logic        frame_start;
      logic        gce_valid;
      logic [2:0]  disposal;
      logic        transparent_flag;
      logic [7:0]  transparent_index;
      logic [15:0] delay_time;
      logic        loop_ext_found;
      logic        bad_signature;
      logic        end_seen;
   } rsp_type;

   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] val;
      unique case (idx)
         2'd0:    val = 8'h47;
         2'd1:    val = 8'h49;
         default: val = 8'h46;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] loop_id_byte(input logic [3:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd0:    val = 8'h4E;
         4'd1:    val = 8'h45;
         4'd2:    val = 8'h54;
         4'd3:    val = 8'h53;
         4'd4:    val = 8'h43;
         4'd5:    val = 8'h41;
         4'd6:    val = 8'h50;
         4'd7:    val = 8'h45;
         4'd8:    val = 8'h32;
         4'd9:    val = 8'h2E;
         default: val = 8'h30;
      endcase
      return val;
   endfunction

   // color table length in bytes from the size field of a packed byte
   function automatic logic [9:0] table_bytes(input logic [2:0] size_field);
      return 10'd3 << ({1'b0, size_field} + 4'd1);
   endfunction

endpackage

// File: rtl/gbsp_if.sv
// ----------------------------------------------------------------------------
// gbsp_if
// valid/ready channels of the gif block stream parser
// ----------------------------------------------------------------------------
interface gbsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;

   modport source (output valid, data_byte, start_of_file, input ready);
   modport sink   (input valid, data_byte, start_of_file, output ready);
endinterface

interface gbsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  region;
   logic [15:0] frame_number;
   logic        frame_start;
   logic        gce_valid;
   logic [2:0]  disposal;
   logic        transparent_flag;
   logic [7:0]  transparent_index;
   logic [15:0] delay_time;
   logic        loop_ext_found;
   logic        bad_signature;
   logic        end_seen;

   modport source (output valid, region, frame_number, frame_start, gce_valid, disposal,
                   transparent_flag, transparent_index, delay_time, loop_ext_found,
                   bad_signature, end_seen, input ready);
   modport sink   (input valid, region, frame_number, frame_start, gce_valid, disposal,
                   transparent_flag, transparent_index, delay_time, loop_ext_found,
                   bad_signature, end_seen, output ready);
endinterface

// File: rtl/gif_block_stream_parser_top.sv
// ----------------------------------------------------------------------------
// gif_block_stream_parser_top
// gif byte stream parser: tags every byte with its block region and decodes
// graphics control extensions, loop extension and frame count
// ----------------------------------------------------------------------------
// One result transaction per byte. A byte is taken every cycle while req.ready
// is high and its result is registered. The parse decision is a
// single pass through the next-state logic of the parser core, so the rate is
// one byte per clock whenever the result side keeps up. A two-entry output
// stage (result register plus skid register) keeps req.ready high while one
// result waits; req.ready drops only when both entries are full.
module gif_block_stream_parser_top #(
   parameter int FRAME_COUNT_BITS = 16
) (
   input logic     clock,
   input logic     reset,
   gbsp_req_if.sink   req,
   gbsp_rsp_if.source rsp
);
   import gbsp_pkg::*;

   req_type req_data;
   rsp_type core_result;
   rsp_type rsp_data_ff, rsp_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    accept;
   logic    slot_free;

   assign req_data.data_byte     = req.data_byte;
   assign req_data.start_of_file = req.start_of_file;
   assign req.ready              = !skid_valid_ff;
   assign accept                 = req.valid && !skid_valid_ff;
   assign slot_free              = !rsp_valid_ff || rsp.ready;

   gbsp_core #(
      .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .result   (core_result)
   );

   always_comb begin
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_valid_in = skid_valid_ff;
      if (slot_free) begin
         if (skid_valid_ff) begin
            rsp_data_in   = skid_data_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_data_in  = core_result;
            rsp_valid_in = accept;
         end
      end else if (accept) begin
         skid_data_in  = core_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.region            = rsp_data_ff.region;
   assign rsp.frame_number      = rsp_data_ff.frame_number;
   assign rsp.frame_start       = rsp_data_ff.frame_start;
   assign rsp.gce_valid         = rsp_data_ff.gce_valid;
   assign rsp.disposal          = rsp_data_ff.disposal;
   assign rsp.transparent_flag  = rsp_data_ff.transparent_flag;
   assign rsp.transparent_index = rsp_data_ff.transparent_index;
   assign rsp.delay_time        = rsp_data_ff.delay_time;
   assign rsp.loop_ext_found    = rsp_data_ff.loop_ext_found;
   assign rsp.bad_signature     = rsp_data_ff.bad_signature;
   assign rsp.end_seen          = rsp_data_ff.end_seen;

endmodule

// File: rtl/gbsp_core.sv
// ----------------------------------------------------------------------------
// gbsp_core
// parse state and next-state decision for one byte of the gif stream
// ----------------------------------------------------------------------------
module gbsp_core #(
   parameter int FRAME_COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  gbsp_pkg::req_type req_data,
   output gbsp_pkg::rsp_type result
);
   import gbsp_pkg::*;

   localparam int FRAME_EXT_BITS = (FRAME_COUNT_BITS > 16) ? FRAME_COUNT_BITS : 16;

   typedef enum logic [17:0] {
      M_HDR   = 18'h00001,
      M_GTAB  = 18'h00002,
      M_TOP   = 18'h00004,
      M_LABEL = 18'h00008,
      M_GCE   = 18'h00010,
      M_APPSZ = 18'h00020,
      M_APPID = 18'h00040,
      M_OLEN  = 18'h00080,
      M_ODAT  = 18'h00100,
      M_LLEN  = 18'h00200,
      M_LDAT  = 18'h00400,
      M_DESC  = 18'h00800,
      M_LTAB  = 18'h01000,
      M_LZW   = 18'h02000,
      M_ILEN  = 18'h04000,
      M_IDAT  = 18'h08000,
      M_END   = 18'h10000,
      M_BAD   = 18'h20000
   } mode_type;

   mode_type                    mode_ff, mode_in, mode_cur;
   logic [9:0]                  byte_count_ff, byte_count_in, byte_count_cur;
   logic [9:0]                  table_length_ff, table_length_in, table_length_cur;
   logic [7:0]                  subblock_left_ff, subblock_left_in, subblock_left_cur;
   logic [7:0]                  screen_packed_ff, screen_packed_in, screen_packed_cur;
   logic [7:0]                  gce_packed_ff, gce_packed_in, gce_packed_cur;
   logic [7:0]                  delay_low_ff, delay_low_in, delay_low_cur;
   logic [7:0]                  delay_high_ff, delay_high_in, delay_high_cur;
   logic [7:0]                  gce_index_ff, gce_index_in, gce_index_cur;
   logic [3:0]                  tag_match_ff, tag_match_in, tag_match_cur;
   logic [FRAME_COUNT_BITS-1:0] frame_count_ff, frame_count_in, frame_count_cur;
   logic                        loop_flag_ff, loop_flag_in, loop_flag_cur;
   logic                        bad_flag_ff, bad_flag_in, bad_flag_cur;
   logic                        ended_flag_ff, ended_flag_in, ended_flag_cur;

   logic [7:0]                  b;
   logic [10:0]                 count_inc;
   logic [7:0]                  sub_dec;
   logic [3:0]                  app_pos;
   logic [FRAME_EXT_BITS-1:0]   frame_ext;
   region_type                  region;

   assign b = req_data.data_byte;

   always_comb begin
      // a start of file byte sees the reset state
      if (req_data.start_of_file) begin
         mode_cur          = M_HDR;
         byte_count_cur    = '0;
         table_length_cur  = '0;
         subblock_left_cur = '0;
         screen_packed_cur = '0;
         gce_packed_cur    = '0;
         delay_low_cur     = '0;
         delay_high_cur    = '0;
         gce_index_cur     = '0;
         tag_match_cur     = '0;
         frame_count_cur   = '0;
         loop_flag_cur     = 1'b0;
         bad_flag_cur      = 1'b0;
         ended_flag_cur    = 1'b0;
      end else begin
         mode_cur          = mode_ff;
         byte_count_cur    = byte_count_ff;
         table_length_cur  = table_length_ff;
         subblock_left_cur = subblock_left_ff;
         screen_packed_cur = screen_packed_ff;
         gce_packed_cur    = gce_packed_ff;
         delay_low_cur     = delay_low_ff;
         delay_high_cur    = delay_high_ff;
         gce_index_cur     = gce_index_ff;
         tag_match_cur     = tag_match_ff;
         frame_count_cur   = frame_count_ff;
         loop_flag_cur     = loop_flag_ff;
         bad_flag_cur      = bad_flag_ff;
         ended_flag_cur    = ended_flag_ff;
      end
   end

   always_comb begin
      mode_in          = mode_cur;
      byte_count_in    = byte_count_cur;
      table_length_in  = table_length_cur;
      subblock_left_in = subblock_left_cur;
      screen_packed_in = screen_packed_cur;
      gce_packed_in    = gce_packed_cur;
      delay_low_in     = delay_low_cur;
      delay_high_in    = delay_high_cur;
      gce_index_in     = gce_index_cur;
      tag_match_in     = tag_match_cur;
      frame_count_in   = frame_count_cur;
      loop_flag_in     = loop_flag_cur;
      bad_flag_in      = bad_flag_cur;
      ended_flag_in    = ended_flag_cur;

      region                   = REGION_STRAY;
      result.frame_start       = 1'b0;
      result.gce_valid         = 1'b0;
      result.disposal          = '0;
      result.transparent_flag  = 1'b0;
      result.transparent_index = '0;
      result.delay_time        = '0;

      count_inc = {1'b0, byte_count_cur} + 11'd1;
      sub_dec   = (subblock_left_cur != 8'd0) ? subblock_left_cur - 8'd1 : 8'd0;
      app_pos   = LOOP_ID_LEN - subblock_left_cur[3:0];

      unique case (mode_cur)
         M_HDR: begin
            region = REGION_HEADER;
            if (byte_count_cur < 10'd3 && b != sig_byte(byte_count_cur[1:0])) begin
               bad_flag_in = 1'b1;
               mode_in     = M_BAD;
               region      = REGION_BAD;
            end else if (byte_count_cur >= 10'd12) begin
               byte_count_in = '0;
               if (screen_packed_cur[TABLE_FLAG]) begin
                  table_length_in = table_bytes(screen_packed_cur[2:0]);
                  mode_in         = M_GTAB;
               end else begin
                  mode_in = M_TOP;
               end
            end else begin
               if (byte_count_cur == 10'd10) begin
                  screen_packed_in = b;
               end
               byte_count_in = count_inc[9:0];
            end
         end
         M_GTAB, M_LTAB: begin
            region        = (mode_cur == M_GTAB) ? REGION_GLOBAL : REGION_LOCAL;
            byte_count_in = count_inc[9:0];
            if (count_inc >= {1'b0, table_length_cur}) begin
               byte_count_in = '0;
               mode_in       = (mode_cur == M_GTAB) ? M_TOP : M_LZW;
            end
         end
         M_TOP: begin
            if (b == EXT_INTRO) begin
               region  = REGION_OTHER_EXT;
               mode_in = M_LABEL;
            end else if (b == IMAGE_SEP) begin
               region             = REGION_DESC;
               result.frame_start = 1'b1;
               if (!(&frame_count_cur)) begin
                  frame_count_in = frame_count_cur + 1'b1;
               end
               byte_count_in = 10'd1;
               mode_in       = M_DESC;
            end else if (b == TRAILER_BYTE) begin
               region        = REGION_TRAILER;
               ended_flag_in = 1'b1;
               mode_in       = M_END;
            end else begin
               region = REGION_STRAY;
            end
         end
         M_LABEL: begin
            if (b == LABEL_GCE) begin
               region        = REGION_GCE;
               byte_count_in = 10'd2;
               mode_in       = M_GCE;
            end else if (b == LABEL_APP) begin
               region  = REGION_OTHER_EXT;
               mode_in = M_APPSZ;
            end else begin
               region  = REGION_OTHER_EXT;
               mode_in = M_OLEN;
            end
         end
         M_GCE: begin
            region = REGION_GCE;
            if (byte_count_cur == 10'd3) begin
               gce_packed_in = b;
            end else if (byte_count_cur == 10'd4) begin
               delay_low_in = b;
            end else if (byte_count_cur == 10'd5) begin
               delay_high_in = b;
            end else if (byte_count_cur == 10'd6) begin
               gce_index_in = b;
            end
            if (byte_count_cur >= 10'd7) begin
               result.gce_valid         = 1'b1;
               result.disposal          = gce_packed_cur[4:2];
               result.transparent_flag  = gce_packed_cur[0];
               result.transparent_index = gce_packed_cur[0] ? gce_index_cur : 8'd0;
               result.delay_time        = {delay_high_cur, delay_low_cur};
               byte_count_in            = '0;
               mode_in                  = M_TOP;
            end else begin
               byte_count_in = count_inc[9:0];
            end
         end
         M_APPSZ: begin
            region = REGION_OTHER_EXT;
            if (b == APP_ID_SIZE) begin
               subblock_left_in = APP_ID_SIZE;
               tag_match_in     = '0;
               mode_in          = M_APPID;
            end else if (b == 8'd0) begin
               mode_in = M_TOP;
            end else begin
               subblock_left_in = b;
               mode_in          = M_ODAT;
            end
         end
         M_APPID: begin
            region = REGION_OTHER_EXT;
            if (subblock_left_cur != 8'd0 && subblock_left_cur <= APP_ID_SIZE
                && tag_match_cur == app_pos && b == loop_id_byte(app_pos)) begin
               tag_match_in = tag_match_cur + 4'd1;
            end
            subblock_left_in = sub_dec;
            if (sub_dec == 8'd0) begin
               if (tag_match_in == LOOP_ID_LEN) begin
                  loop_flag_in = 1'b1;
                  region       = REGION_LOOP_EXT;
                  mode_in      = M_LLEN;
               end else begin
                  mode_in = M_OLEN;
               end
            end
         end
         M_OLEN, M_LLEN, M_ILEN: begin
            unique case (mode_cur)
               M_OLEN:  region = REGION_OTHER_EXT;
               M_LLEN:  region = REGION_LOOP_EXT;
               default: region = REGION_IMAGE;
            endcase
            if (b == 8'd0) begin
               mode_in = M_TOP;
            end else begin
               subblock_left_in = b;
               unique case (mode_cur)
                  M_OLEN:  mode_in = M_ODAT;
                  M_LLEN:  mode_in = M_LDAT;
                  default: mode_in = M_IDAT;
               endcase
            end
         end
         M_ODAT, M_LDAT, M_IDAT: begin
            unique case (mode_cur)
               M_ODAT:  region = REGION_OTHER_EXT;
               M_LDAT:  region = REGION_LOOP_EXT;
               default: region = REGION_IMAGE;
            endcase
            subblock_left_in = sub_dec;
            if (sub_dec == 8'd0) begin
               unique case (mode_cur)
                  M_ODAT:  mode_in = M_OLEN;
                  M_LDAT:  mode_in = M_LLEN;
                  default: mode_in = M_ILEN;
               endcase
            end
         end
         M_DESC: begin
            region = REGION_DESC;
            if (byte_count_cur >= 10'd9) begin
               byte_count_in = '0;
               if (b[TABLE_FLAG]) begin
                  table_length_in = table_bytes(b[2:0]);
                  mode_in         = M_LTAB;
               end else begin
                  mode_in = M_LZW;
               end
            end else begin
               byte_count_in = count_inc[9:0];
            end
         end
         M_LZW: begin
            region  = REGION_IMAGE;
            mode_in = M_ILEN;
         end
         M_END: begin
            region = REGION_AFTER_END;
         end
         default: begin
            region = REGION_BAD;
         end
      endcase

      frame_ext             = FRAME_EXT_BITS'(frame_count_in);
      result.region         = region;
      result.frame_number   = frame_ext[15:0];
      result.loop_ext_found = loop_flag_in;
      result.bad_signature  = bad_flag_in;
      result.end_seen       = ended_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= M_HDR;
         byte_count_ff    <= '0;
         table_length_ff  <= '0;
         subblock_left_ff <= '0;
         screen_packed_ff <= '0;
         gce_packed_ff    <= '0;
         delay_low_ff     <= '0;
         delay_high_ff    <= '0;
         gce_index_ff     <= '0;
         tag_match_ff     <= '0;
         frame_count_ff   <= '0;
         loop_flag_ff     <= 1'b0;
         bad_flag_ff      <= 1'b0;
         ended_flag_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff          <= mode_in;
         byte_count_ff    <= byte_count_in;
         table_length_ff  <= table_length_in;
         subblock_left_ff <= subblock_left_in;
         screen_packed_ff <= screen_packed_in;
         gce_packed_ff    <= gce_packed_in;
         delay_low_ff     <= delay_low_in;
         delay_high_ff    <= delay_high_in;
         gce_index_ff     <= gce_index_in;
         tag_match_ff     <= tag_match_in;
         frame_count_ff   <= frame_count_in;
         loop_flag_ff     <= loop_flag_in;
         bad_flag_ff      <= bad_flag_in;
         ended_flag_ff    <= ended_flag_in;
      end
   end

endmodule

// File: rtl/gbsp_checker.sv
// ----------------------------------------------------------------------------
// gbsp_checker
// port-level assertions on the gif block stream parser
// ----------------------------------------------------------------------------
`include "gif_block_stream_parser_top_macros.svh"

module gbsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_region,
   input logic        rsp_frame_start,
   input logic        rsp_gce_valid,
   input logic [2:0]  rsp_disposal,
   input logic        rsp_transparent_flag,
   input logic [7:0]  rsp_transparent_index,
   input logic [15:0] rsp_delay_time
);
   import gbsp_pkg::*;

   `GBSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_region) && $stable(rsp_delay_time), "stalled result changed")
   `GBSP_ASSERT_IMPL(a_region_range, clock, reset, rsp_valid, rsp_region <= REGION_BAD, "region code out of range")
   `GBSP_ASSERT_IMPL(a_frame_start_desc, clock, reset, rsp_valid && rsp_frame_start, rsp_region == REGION_DESC && !rsp_gce_valid, "frame start outside a descriptor")
   `GBSP_ASSERT_IMPL(a_gce_fields_zero, clock, reset, rsp_valid && !rsp_gce_valid, rsp_disposal == 3'd0 && !rsp_transparent_flag && rsp_delay_time == 16'd0, "gce fields set without gce")
   `GBSP_ASSERT_IMPL(a_index_flag, clock, reset, rsp_valid && !rsp_transparent_flag, rsp_transparent_index == 8'd0, "transparent index without flag")

endmodule

bind gif_block_stream_parser_top gbsp_checker u_gbsp_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp.valid),
   .rsp_ready             (rsp.ready),
   .rsp_region            (rsp.region),
   .rsp_frame_start       (rsp.frame_start),
   .rsp_gce_valid         (rsp.gce_valid),
   .rsp_disposal          (rsp.disposal),
   .rsp_transparent_flag  (rsp.transparent_flag),
   .rsp_transparent_index (rsp.transparent_index),
   .rsp_delay_time        (rsp.delay_time)
);
